// File: src/rgb_led_pixel_serializer_top_assert.svh
// Assertion macros used by the serializer top.
`ifndef RGB_LED_PIXEL_SERIALIZER_TOP_ASSERT_SVH
`define RGB_LED_PIXEL_SERIALIZER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define RLPS_ASSERT_IMPLY(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("rlps: implication check failed");
`define RLPS_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("rlps: next-cycle check failed");
`else
`define RLPS_ASSERT_IMPLY(label, clk, rst, cond, prop)
`define RLPS_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

// File: src/rlps_pkg.sv
package rlps_pkg;

  localparam int BITS_PER_PIXEL = 24;
  localparam int BIT_CNT_W      = $clog2(BITS_PER_PIXEL + 1);
  localparam int TICK_W         = 8;
  localparam int CFG_IDX_W      = 8;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW  = CFG_IDX_W'(3);

  localparam logic [TICK_W-1:0] ONE_HIGH_RST  = TICK_W'(5);
  localparam logic [TICK_W-1:0] ONE_LOW_RST   = TICK_W'(1);
  localparam logic [TICK_W-1:0] ZERO_HIGH_RST = TICK_W'(1);
  localparam logic [TICK_W-1:0] ZERO_LOW_RST  = TICK_W'(5);

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  // classified word handed from front to back
  typedef struct packed {
    op_t                       op;
    logic [BITS_PER_PIXEL-1:0] grb;
    logic                      last;
  } entry_t;

  // ch * b / 255, truncated; exact for any 16-bit product
  function automatic logic [7:0] scale_ch(input logic [7:0] ch, input logic [7:0] b);
    logic [15:0] prod;
    logic [16:0] sum;
    prod = {8'd0, ch} * {8'd0, b};
    sum  = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

  // a zero register still gives a one-tick phase
  function automatic logic [TICK_W-1:0] phase_len(input logic [TICK_W-1:0] v);
    return (v == '0) ? TICK_W'(1) : v;
  endfunction

endpackage

// File: src/rlps_if.sv
interface rlps_pixel_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [23:0] color;
  logic [7:0]  brightness;
  logic        last_pixel;

  modport source (output valid, operation, color, brightness, last_pixel, input ready);
  modport sink   (input valid, operation, color, brightness, last_pixel, output ready);
endinterface

interface rlps_result_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic busy_res;
  logic load_accepted;
  logic frame_done;

  modport source (output valid, pin_level, busy_res, load_accepted, frame_done, input ready);
  modport sink   (input valid, pin_level, busy_res, load_accepted, frame_done, output ready);
endinterface

interface rlps_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/rlps_front.sv
module rlps_front (
  rlps_pixel_if.sink      pixel_in,
  input  logic            full,
  output logic            push,
  output rlps_pkg::entry_t push_entry
);
  import rlps_pkg::*;

  logic [7:0] r_s;
  logic [7:0] g_s;
  logic [7:0] b_s;

  assign pixel_in.ready = !full;
  assign push           = pixel_in.valid && !full;

  assign r_s = scale_ch(pixel_in.color[23:16], pixel_in.brightness);
  assign g_s = scale_ch(pixel_in.color[15:8],  pixel_in.brightness);
  assign b_s = scale_ch(pixel_in.color[7:0],   pixel_in.brightness);

  always_comb begin
    push_entry.op   = op_t'(pixel_in.operation);
    push_entry.grb  = {g_s, r_s, b_s};
    push_entry.last = pixel_in.last_pixel;
  end

endmodule

// File: src/rlps_fifo.sv
module rlps_fifo #(
  parameter int DEPTH = rlps_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rlps_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output rlps_pkg::entry_t pop_entry,
  output logic             empty
);
  import rlps_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  entry_t            slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: src/rlps_back.sv
module rlps_back (
  input  logic             clk,
  input  logic             rst,
  rlps_cfg_if.sink         cfg,
  input  logic             empty,
  input  rlps_pkg::entry_t pop_entry,
  output logic             pop,
  rlps_result_if.source    result_out
);
  import rlps_pkg::*;

  logic [TICK_W-1:0]         one_high;
  logic [TICK_W-1:0]         one_low;
  logic [TICK_W-1:0]         zero_high;
  logic [TICK_W-1:0]         zero_low;

  logic [BITS_PER_PIXEL-1:0] shift_bits;
  logic [BITS_PER_PIXEL-1:0] shift_bits_next;
  logic [BIT_CNT_W-1:0]      bits_left;
  logic [BIT_CNT_W-1:0]      bits_left_next;
  logic                      in_high;
  logic                      in_high_next;
  logic [TICK_W-1:0]         phase_left;
  logic [TICK_W-1:0]         phase_left_next;
  logic                      sending;
  logic                      sending_next;
  logic                      frame_pend;
  logic                      frame_pend_next;

  logic                      pin;
  logic                      accepted;
  logic                      done;
  logic [TICK_W-1:0]         phase_dec;
  logic [BIT_CNT_W-1:0]      bits_dec;
  logic [BITS_PER_PIXEL-1:0] shifted;

  assign cfg.ready = 1'b1;
  assign pop       = !empty && (!result_out.valid || result_out.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      one_high  <= ONE_HIGH_RST;
      one_low   <= ONE_LOW_RST;
      zero_high <= ZERO_HIGH_RST;
      zero_low  <= ZERO_LOW_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_ONE_HIGH:  one_high  <= cfg.data;
        CFG_ONE_LOW:   one_low   <= cfg.data;
        CFG_ZERO_HIGH: zero_high <= cfg.data;
        CFG_ZERO_LOW:  zero_low  <= cfg.data;
        default: ;
      endcase
    end
  end

  assign phase_dec = (phase_left != '0) ? phase_left - TICK_W'(1) : '0;
  assign bits_dec  = (bits_left != '0) ? bits_left - BIT_CNT_W'(1) : '0;
  assign shifted   = {shift_bits[BITS_PER_PIXEL-2:0], 1'b0};
  assign pin       = sending && in_high;

  always_comb begin
    shift_bits_next = shift_bits;
    bits_left_next  = bits_left;
    in_high_next    = in_high;
    phase_left_next = phase_left;
    sending_next    = sending;
    frame_pend_next = frame_pend;
    accepted        = 1'b0;
    done            = 1'b0;
    if (pop_entry.op == OP_LOAD) begin
      if (!sending) begin
        shift_bits_next = pop_entry.grb;
        bits_left_next  = BIT_CNT_W'(BITS_PER_PIXEL);
        sending_next    = 1'b1;
        frame_pend_next = pop_entry.last;
        in_high_next    = 1'b1;
        phase_left_next = phase_len(pop_entry.grb[BITS_PER_PIXEL-1] ? one_high : zero_high);
        accepted        = 1'b1;
      end
    end else if (sending) begin
      phase_left_next = phase_dec;
      if (phase_dec == '0) begin
        if (in_high) begin
          in_high_next    = 1'b0;
          phase_left_next = phase_len(shift_bits[BITS_PER_PIXEL-1] ? one_low : zero_low);
        end else begin
          shift_bits_next = shifted;
          bits_left_next  = bits_dec;
          if (bits_dec == '0) begin
            sending_next    = 1'b0;
            in_high_next    = 1'b0;
            done            = frame_pend;
            frame_pend_next = 1'b0;
          end else begin
            in_high_next    = 1'b1;
            phase_left_next = phase_len(shifted[BITS_PER_PIXEL-1] ? one_high : zero_high);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_bits <= '0;
      bits_left  <= '0;
      in_high    <= 1'b0;
      phase_left <= '0;
      sending    <= 1'b0;
      frame_pend <= 1'b0;
    end else if (pop) begin
      shift_bits <= shift_bits_next;
      bits_left  <= bits_left_next;
      in_high    <= in_high_next;
      phase_left <= phase_left_next;
      sending    <= sending_next;
      frame_pend <= frame_pend_next;
    end
  end

  // output register; refilled in the same cycle it drains
  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (pop) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result_out.pin_level     <= pin;
      result_out.busy_res      <= sending_next;
      result_out.load_accepted <= accepted;
      result_out.frame_done    <= done;
    end
  end

endmodule

// File: src/rgb_led_pixel_serializer_top.sv
// Channel     Dir  Fields
// pixel_in    in   operation, color[23:0], brightness[7:0], last_pixel
// result_out  out  pin_level, busy_res, load_accepted, frame_done
// cfg         in   index[7:0], data[7:0]  (always ready)
//
// One word in and one word out per cycle while result_out does not stall; each word
// is written into the front queue, then the sequencer step puts it into the output register.
// The sequencer updates line state once per word, so its one-step loop sets the rate.
// rst is synchronous: timing registers return to 5/1/1/5, the line goes idle low.
// A stall on result_out backs up the queue (QUEUE_DEPTH words) before pixel_in drops ready.
`include "rgb_led_pixel_serializer_top_assert.svh"

module rgb_led_pixel_serializer_top #(
  parameter int QUEUE_DEPTH = rlps_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  rlps_pixel_if.sink    pixel_in,
  rlps_result_if.source result_out,
  rlps_cfg_if.sink      cfg
);
  import rlps_pkg::*;

  logic   push;
  logic   pop;
  logic   full;
  logic   empty;
  entry_t push_entry;
  entry_t pop_entry;

  rlps_front u_front (
    .pixel_in   (pixel_in),
    .full       (full),
    .push       (push),
    .push_entry (push_entry)
  );

  rlps_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .empty      (empty)
  );

  rlps_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .empty      (empty),
    .pop_entry  (pop_entry),
    .pop        (pop),
    .result_out (result_out)
  );

  // frame end always lands in a low phase and leaves the line idle
  `RLPS_ASSERT_IMPLY(a_done_idle, clk, rst, result_out.valid && result_out.frame_done, !result_out.busy_res && !result_out.pin_level && !result_out.load_accepted)
  // a taken load starts a pixel
  `RLPS_ASSERT_IMPLY(a_load_busy, clk, rst, result_out.valid && result_out.load_accepted, result_out.busy_res)
  // queued work with a free output slot must show up next cycle
  `RLPS_ASSERT_NEXT(a_drain, clk, rst, !empty && (!result_out.valid || result_out.ready), result_out.valid)

endmodule
